### src/mtb_pkg.sv
// mtb_pkg: shared types and codes for the multi timer bank
// no dependencies; used by multi_timer_bank_top and the testbench
`default_nettype none

package mtb_pkg;

	// operation codes carried on the func field
	typedef enum logic [2:0] {
		F_TICK      = 3'd0,
		F_SET       = 3'd1,
		F_CLEAR     = 3'd2,
		F_PAUSE     = 3'd3,
		F_UNPAUSE   = 3'd4,
		F_READ      = 3'd5,
		F_ADD       = 3'd6,
		F_CLR_OWNER = 3'd7
	} func_t;

	// result kinds
	typedef enum logic [1:0] {
		K_ACK       = 2'd0,
		K_EXPIRED   = 2'd1,
		K_TICK_DONE = 2'd2
	} kind_t;

	// result status codes
	typedef enum logic [1:0] {
		S_OK      = 2'd0,
		S_UNKNOWN = 2'd1,
		S_NO_FREE = 2'd2
	} status_t;

	// per-slot lifecycle
	typedef enum logic [1:0] {
		SS_FREE   = 2'd0,
		SS_ACTIVE = 2'd1,
		SS_PAUSED = 2'd2
	} slot_st_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_WALK = 2'd1,
		ST_DONE = 2'd2
	} fsm_t;

	localparam int SLOT_W = 4;
	localparam int AMT_W  = 32;
	localparam int OWN_W  = 8;

endpackage

`default_nettype wire

### src/mtb_ram.sv
// mtb_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module mtb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                                     clk,
	input  wire                                     we,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire [WIDTH-1:0]                         wdata,
	input  wire                                     re,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### src/multi_timer_bank_top.sv
// multi timer bank: tick and clear owner issue all SLOTS slots one per cycle unless a stalled
// beat holds the walk, then execute the last slot, end the walk and send the closing beat;
// set walks from slot 0 and stops at the lowest free slot, or sends a closing no-free beat
// when the bank is full; single slot operations issue only their own slot and give one beat.
// A new item is taken only once the sequencer is back in idle.
// Reset frees every slot at once; the slot memory itself is never cleared.
`default_nettype none

module multi_timer_bank_top #(
	parameter int SLOTS      = 16,
	parameter int TIME_BITS  = 32,
	parameter int OWNER_BITS = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	// input channel
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [2:0]  func,
	input  wire  [3:0]  slot,
	input  wire  [31:0] amount,
	input  wire         looping,
	input  wire  [7:0]  owner,
	// result channel
	output logic        out_valid,
	input  wire         out_ready,
	output logic [1:0]  kind,
	output logic [3:0]  timer_slot,
	output logic [31:0] remaining,
	output logic [1:0]  status,
	output logic        last
);

	localparam int IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int WB     = ((TIME_BITS > 32) ? TIME_BITS : 32) + 2;
	localparam int WORD_W = 2 * TIME_BITS + 1 + OWNER_BITS;

	localparam logic signed [WB-1:0] TMAX_W =
		{{(WB-TIME_BITS+1){1'b0}}, {(TIME_BITS-1){1'b1}}};
	localparam logic signed [WB-1:0] TMIN_W =
		{{(WB-TIME_BITS+1){1'b1}}, {(TIME_BITS-1){1'b0}}};
	localparam logic signed [WB-1:0] S32MAX_W = {{(WB-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [WB-1:0] S32MIN_W = {{(WB-31){1'b1}}, {31{1'b0}}};

	// sign extension and saturation helpers
	function automatic logic signed [WB-1:0] ext_t(input logic [TIME_BITS-1:0] t);
		ext_t = {{(WB-TIME_BITS){t[TIME_BITS-1]}}, t};
	endfunction

	function automatic logic signed [WB-1:0] ext_a(input logic [31:0] a);
		ext_a = {{(WB-32){a[31]}}, a};
	endfunction

	function automatic logic [TIME_BITS-1:0] clamp_t(input logic signed [WB-1:0] v);
		if (v > TMAX_W) begin
			clamp_t = TMAX_W[TIME_BITS-1:0];
		end else if (v < TMIN_W) begin
			clamp_t = TMIN_W[TIME_BITS-1:0];
		end else begin
			clamp_t = v[TIME_BITS-1:0];
		end
	endfunction

	function automatic logic [31:0] clamp_32(input logic signed [WB-1:0] v);
		if (v > S32MAX_W) begin
			clamp_32 = S32MAX_W[31:0];
		end else if (v < S32MIN_W) begin
			clamp_32 = S32MIN_W[31:0];
		end else begin
			clamp_32 = v[31:0];
		end
	endfunction

	// sequencer and item registers
	mtb_pkg::fsm_t     state_q, state_d;
	mtb_pkg::func_t    func_q;
	logic [3:0]        slot_q;
	logic              slot_ok_q;
	logic [31:0]       amount_q;
	logic              loop_q;
	logic [OWNER_BITS-1:0] own_q;
	logic              single_q;

	logic [IW-1:0]     ptr_q;
	logic              iss_done_q;
	logic              found_q;
	logic              valid_s1;
	logic [IW-1:0]     idx_s1;

	mtb_pkg::slot_st_t slot_st_q [SLOTS];

	// output register
	logic              out_valid_q;
	mtb_pkg::kind_t    kind_q;
	logic [3:0]        tslot_q;
	logic [31:0]       rem_q;
	mtb_pkg::status_t  status_q;
	logic              last_q;

	logic              accept;
	logic              walking;
	logic              fin_need;
	logic              out_can_load;
	logic              stall;
	logic              issue;
	logic              exec_load;
	logic              fin_load;
	logic              commit;

	// input field conversions
	logic [OWNER_BITS+7:0] own_wide;
	logic [IW+3:0]         slot_wide;
	logic [IW+3:0]         idx_wide;
	logic [3:0]            idx4;
	logic                  single_in;

	assign own_wide  = {{OWNER_BITS{1'b0}}, owner};
	assign slot_wide = {{IW{1'b0}}, slot};
	assign idx_wide  = {4'b0000, idx_s1};
	assign idx4      = idx_wide[3:0];
	assign single_in = !(mtb_pkg::func_t'(func) == mtb_pkg::F_TICK ||
		mtb_pkg::func_t'(func) == mtb_pkg::F_SET ||
		mtb_pkg::func_t'(func) == mtb_pkg::F_CLR_OWNER);

	// slot memory: {time left, reload, periodic, owner}
	logic              ram_we_c;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;

	mtb_ram #(
		.WIDTH(WORD_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we_c && commit),
		.waddr(idx_s1),
		.wdata(ram_wdata),
		.re   (issue),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	logic [TIME_BITS-1:0]  rd_time;
	logic [TIME_BITS-1:0]  rd_reload;
	logic                  rd_per;
	logic [OWNER_BITS-1:0] rd_own;

	assign rd_time   = ram_rdata[WORD_W-1 -: TIME_BITS];
	assign rd_reload = ram_rdata[WORD_W-1-TIME_BITS -: TIME_BITS];
	assign rd_per    = ram_rdata[OWNER_BITS];
	assign rd_own    = ram_rdata[OWNER_BITS-1:0];

	// shared saturating adder: subtract for tick, add otherwise
	logic signed [WB-1:0] alu_sum;
	logic [TIME_BITS-1:0] alu_res;
	logic [TIME_BITS-1:0] set_time;
	logic                 expire;

	assign alu_sum  = ext_t(rd_time) + ((func_q == mtb_pkg::F_TICK) ?
		-ext_a(amount_q) : ext_a(amount_q));
	assign alu_res  = clamp_t(alu_sum);
	assign set_time = clamp_t(ext_a(amount_q));
	assign expire   = alu_res[TIME_BITS-1] || (alu_res == '0);

	// execute stage
	mtb_pkg::slot_st_t cur_st;
	logic              known;
	logic              ex_emit;
	mtb_pkg::kind_t    ex_kind;
	logic [3:0]        ex_slot;
	logic [31:0]       ex_rem;
	mtb_pkg::status_t  ex_status;
	logic              ex_last;
	logic              st_we_c;
	mtb_pkg::slot_st_t st_val;
	logic              set_hit;

	assign cur_st = slot_st_q[idx_s1];
	assign known  = slot_ok_q && (cur_st != mtb_pkg::SS_FREE);

	always_comb begin
		ex_emit   = 1'b0;
		ex_kind   = mtb_pkg::K_ACK;
		ex_slot   = slot_q;
		ex_rem    = '0;
		ex_status = mtb_pkg::S_OK;
		ex_last   = 1'b1;
		ram_we_c  = 1'b0;
		ram_wdata = ram_rdata;
		st_we_c   = 1'b0;
		st_val    = mtb_pkg::SS_FREE;
		set_hit   = 1'b0;
		if (valid_s1) begin
			unique case (func_q)
				mtb_pkg::F_TICK: begin
					if (cur_st == mtb_pkg::SS_ACTIVE) begin
						ram_we_c = 1'b1;
						ram_wdata = {alu_res, rd_reload, rd_per, rd_own};
						if (expire) begin
							ex_emit = 1'b1;
							ex_kind = mtb_pkg::K_EXPIRED;
							ex_slot = idx4;
							ex_last = 1'b0;
							if (rd_per) begin
								ram_wdata = {rd_reload, rd_reload, rd_per, rd_own};
							end else begin
								st_we_c = 1'b1;
								st_val  = mtb_pkg::SS_FREE;
							end
						end
					end
				end
				mtb_pkg::F_SET: begin
					if (!found_q && cur_st == mtb_pkg::SS_FREE) begin
						set_hit   = 1'b1;
						ex_emit   = 1'b1;
						ex_slot   = idx4;
						ram_we_c  = 1'b1;
						ram_wdata = {set_time, set_time, loop_q, own_q};
						st_we_c   = 1'b1;
						st_val    = mtb_pkg::SS_ACTIVE;
					end
				end
				mtb_pkg::F_CLR_OWNER: begin
					if (cur_st != mtb_pkg::SS_FREE && rd_own == own_q) begin
						st_we_c = 1'b1;
						st_val  = mtb_pkg::SS_FREE;
					end
				end
				mtb_pkg::F_CLEAR, mtb_pkg::F_PAUSE, mtb_pkg::F_UNPAUSE,
				mtb_pkg::F_READ, mtb_pkg::F_ADD: begin
					ex_emit = 1'b1;
					if (!known) begin
						ex_status = mtb_pkg::S_UNKNOWN;
						ex_rem    = (func_q == mtb_pkg::F_READ) ? '1 : '0;
					end else begin
						unique case (func_q)
							mtb_pkg::F_CLEAR: begin
								st_we_c = 1'b1;
								st_val  = mtb_pkg::SS_FREE;
							end
							mtb_pkg::F_PAUSE: begin
								st_we_c = 1'b1;
								st_val  = mtb_pkg::SS_PAUSED;
							end
							mtb_pkg::F_UNPAUSE: begin
								st_we_c = 1'b1;
								st_val  = mtb_pkg::SS_ACTIVE;
							end
							mtb_pkg::F_READ: begin
								ex_rem = clamp_32(ext_t(rd_time));
							end
							default: begin
								ram_we_c  = 1'b1;
								ram_wdata = {alu_res, rd_reload, rd_per, rd_own};
							end
						endcase
					end
				end
				default: begin
					ex_emit = 1'b0;
				end
			endcase
		end
	end

	// handshake and pipeline control
	assign out_can_load = !out_valid_q || out_ready;
	assign stall        = valid_s1 && ex_emit && !out_can_load;
	assign commit       = valid_s1 && !stall;
	assign accept       = in_valid && in_ready;
	assign issue        = walking && !iss_done_q && !found_q && !stall;
	assign exec_load    = valid_s1 && ex_emit && out_can_load;
	assign fin_load     = fin_need && out_can_load;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mtb_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = mtb_pkg::ST_WALK;
				end
			end
			mtb_pkg::ST_WALK: begin
				if ((iss_done_q || found_q) && !valid_s1) begin
					state_d = mtb_pkg::ST_DONE;
				end
			end
			mtb_pkg::ST_DONE: begin
				if (!fin_need || out_can_load) begin
					state_d = mtb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mtb_pkg::ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		walking  = 1'b0;
		fin_need = 1'b0;
		unique case (state_q)
			mtb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			mtb_pkg::ST_WALK: begin
				walking = 1'b1;
			end
			mtb_pkg::ST_DONE: begin
				fin_need = (func_q == mtb_pkg::F_TICK) ||
					(func_q == mtb_pkg::F_CLR_OWNER) ||
					(func_q == mtb_pkg::F_SET && !found_q);
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mtb_pkg::ST_IDLE;
			valid_s1    <= 1'b0;
			iss_done_q  <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				slot_st_q[i] <= mtb_pkg::SS_FREE;
			end
		end else begin
			state_q <= state_d;
			if (accept) begin
				iss_done_q <= 1'b0;
				found_q    <= 1'b0;
			end else begin
				if (issue && (single_q || ptr_q == IW'(SLOTS - 1))) begin
					iss_done_q <= 1'b1;
				end
				if (set_hit && commit) begin
					found_q <= 1'b1;
				end
			end
			if (!stall) begin
				valid_s1 <= issue;
			end
			if (st_we_c && commit) begin
				slot_st_q[idx_s1] <= st_val;
			end
			if (exec_load || fin_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item and walk payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= mtb_pkg::func_t'(func);
			slot_q    <= slot;
			slot_ok_q <= ({3'b000, slot} < 7'(SLOTS));
			amount_q  <= amount;
			loop_q    <= looping;
			own_q     <= own_wide[OWNER_BITS-1:0];
			single_q  <= single_in;
			ptr_q     <= single_in ? slot_wide[IW-1:0] : '0;
		end else if (issue) begin
			ptr_q <= ptr_q + IW'(1);
		end
		if (issue) begin
			idx_s1 <= ptr_q;
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (exec_load) begin
			kind_q   <= ex_kind;
			tslot_q  <= ex_slot;
			rem_q    <= ex_rem;
			status_q <= ex_status;
			last_q   <= ex_last;
		end else if (fin_load) begin
			kind_q   <= (func_q == mtb_pkg::F_TICK) ? mtb_pkg::K_TICK_DONE : mtb_pkg::K_ACK;
			tslot_q  <= '0;
			rem_q    <= '0;
			status_q <= (func_q == mtb_pkg::F_SET) ? mtb_pkg::S_NO_FREE : mtb_pkg::S_OK;
			last_q   <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign timer_slot = tslot_q;
	assign remaining  = rem_q;
	assign status     = status_q;
	assign last       = last_q;

`ifndef ASSERT_OFF
	// no slot is in flight while a new item may enter
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !valid_s1)
		else $error("slot in flight while ready");

	// a stalled slot holds its place until the beat can leave
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> valid_s1 && $stable(idx_s1))
		else $error("stalled slot lost");

	// a found slot only ever comes from a set
	a_found_set: assert property (@(posedge clk) disable iff (!arst_n)
		found_q && walking |-> func_q == mtb_pkg::F_SET)
		else $error("found flag outside set");

	// memory writes only come from the execute stage
	a_we_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we_c |-> valid_s1)
		else $error("memory write without slot");
`endif

endmodule

`default_nettype wire

### test/tb_multi_timer_bank_top.sv
// testbench for multi_timer_bank_top: random and directed timer operations against a
// built-in model of the slot bank, with random idle beats on both channels
// depends on mtb_pkg and multi_timer_bank_top
`timescale 1ns / 1ps

module tb_multi_timer_bank_top;

	localparam int     NUM_SLOTS      = 16;
	localparam int     DIRECTED_OPS   = 25;
	localparam int     RANDOM_OPS     = 325;
	localparam int     SETTLE_CYCLES  = 40;
	// at most 367 operations, up to 17 results each, and every result open to a stall on the sink
	localparam int     CYCLE_LIMIT    = 1000000;
	localparam int     REPORT_LIMIT   = 10;
	localparam longint TIME_MAX       = 64'sd2147483647;
	localparam longint TIME_MIN       = -64'sd2147483648;

	typedef struct {
		mtb_pkg::func_t func;
		logic [3:0]     slot;
		logic [31:0]    amount;
		logic           looping;
		logic [7:0]     owner;
		bit             drain;
	} timer_op_t;

	typedef struct {
		mtb_pkg::kind_t   kind;
		logic [3:0]       slot;
		logic [31:0]      remaining;
		mtb_pkg::status_t status;
		logic             last;
	} timer_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  op_func = '0;
	logic [3:0]  op_slot = '0;
	logic [31:0] op_amount = '0;
	logic        op_looping = 1'b0;
	logic [7:0]  op_owner = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  res_kind;
	logic [3:0]  res_slot;
	logic [31:0] res_remaining;
	logic [1:0]  res_status;
	logic        res_last;

	multi_timer_bank_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (op_func),
		.slot      (op_slot),
		.amount    (op_amount),
		.looping   (op_looping),
		.owner     (op_owner),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (res_kind),
		.timer_slot(res_slot),
		.remaining (res_remaining),
		.status    (res_status),
		.last      (res_last)
	);

	// shadow copy of the slot bank
	mtb_pkg::slot_st_t  bank_state    [NUM_SLOTS];
	logic signed [31:0] bank_left     [NUM_SLOTS];
	logic signed [31:0] bank_reload   [NUM_SLOTS];
	bit                 bank_periodic [NUM_SLOTS];
	logic [7:0]         bank_owner    [NUM_SLOTS];

	timer_op_t    op_queue[$];
	timer_event_t due_events[$];

	bit  in_beat = 1'b0;
	bit  send_calm = 1'b0;
	bit  sink_calm = 1'b0;
	int  send_gap = 0;
	int  sink_wait = 0;
	int  queued_ops = 0;
	int  cycles = 0;
	int  errors = 0;
	int  results_seen = 0;
	int  expiries_seen = 0;
	int  refusals_seen = 0;
	int  unknown_seen = 0;
	int  op_count [8];
	logic [7:0] tag_pool [4];

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [31:0] sat32(longint v);
		if (v > TIME_MAX)
			return 32'h7fff_ffff;
		if (v < TIME_MIN)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	task automatic push_event(mtb_pkg::kind_t k, logic [3:0] s, logic [31:0] rem,
			mtb_pkg::status_t st, logic lst);
		timer_event_t ev;
		ev.kind = k;
		ev.slot = s;
		ev.remaining = rem;
		ev.status = st;
		ev.last = lst;
		due_events.insert(due_events.size(), ev);
	endtask

	// apply one accepted operation to the shadow bank and queue its results
	task automatic bank_step(timer_op_t op);
		longint amt;
		int     found;
		amt = longint'($signed(op.amount));
		found = -1;
		case (op.func)
			mtb_pkg::F_TICK: begin
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (bank_state[i] == mtb_pkg::SS_ACTIVE) begin
						bank_left[i] = sat32(longint'(bank_left[i]) - amt);
						if (bank_left[i] <= 0) begin
							push_event(mtb_pkg::K_EXPIRED, 4'(i), '0, mtb_pkg::S_OK, 1'b0);
							if (bank_periodic[i])
								bank_left[i] = bank_reload[i];
							else
								bank_state[i] = mtb_pkg::SS_FREE;
						end
					end
				end
				push_event(mtb_pkg::K_TICK_DONE, '0, '0, mtb_pkg::S_OK, 1'b1);
			end
			mtb_pkg::F_SET: begin
				for (int i = NUM_SLOTS - 1; i >= 0; i--)
					if (bank_state[i] == mtb_pkg::SS_FREE)
						found = i;
				if (found < 0) begin
					push_event(mtb_pkg::K_ACK, '0, '0, mtb_pkg::S_NO_FREE, 1'b1);
				end else begin
					bank_state[found] = mtb_pkg::SS_ACTIVE;
					bank_left[found] = op.amount;
					bank_reload[found] = op.amount;
					bank_periodic[found] = op.looping;
					bank_owner[found] = op.owner;
					push_event(mtb_pkg::K_ACK, 4'(found), '0, mtb_pkg::S_OK, 1'b1);
				end
			end
			mtb_pkg::F_CLR_OWNER: begin
				for (int i = 0; i < NUM_SLOTS; i++)
					if (bank_state[i] != mtb_pkg::SS_FREE && bank_owner[i] == op.owner)
						bank_state[i] = mtb_pkg::SS_FREE;
				push_event(mtb_pkg::K_ACK, '0, '0, mtb_pkg::S_OK, 1'b1);
			end
			default: begin
				if (bank_state[op.slot] == mtb_pkg::SS_FREE) begin
					push_event(mtb_pkg::K_ACK, op.slot,
						(op.func == mtb_pkg::F_READ) ? 32'hffff_ffff : 32'h0,
						mtb_pkg::S_UNKNOWN, 1'b1);
				end else if (op.func == mtb_pkg::F_READ) begin
					push_event(mtb_pkg::K_ACK, op.slot, bank_left[op.slot], mtb_pkg::S_OK,
						1'b1);
				end else begin
					case (op.func)
						mtb_pkg::F_CLEAR:   bank_state[op.slot] = mtb_pkg::SS_FREE;
						mtb_pkg::F_PAUSE:   bank_state[op.slot] = mtb_pkg::SS_PAUSED;
						mtb_pkg::F_UNPAUSE: bank_state[op.slot] = mtb_pkg::SS_ACTIVE;
						default:
							bank_left[op.slot] = sat32(longint'(bank_left[op.slot]) + amt);
					endcase
					push_event(mtb_pkg::K_ACK, op.slot, '0, mtb_pkg::S_OK, 1'b1);
				end
			end
		endcase
	endtask

	task automatic push_op(mtb_pkg::func_t f, logic [3:0] s, logic [31:0] a, logic l,
			logic [7:0] o, bit d);
		timer_op_t op;
		op.func = f;
		op.slot = s;
		op.amount = a;
		op.looping = l;
		op.owner = o;
		op.drain = d;
		op_queue.insert(op_queue.size(), op);
		queued_ops++;
	endtask

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 20);
	endfunction

	function automatic logic [31:0] pick_between(int lo, int hi);
		return 32'(lo + int'($urandom_range(0, hi - lo)));
	endfunction

	// mostly a slot that is in use, else any handle
	function automatic logic [3:0] pick_live();
		int base;
		base = $urandom_range(0, NUM_SLOTS - 1);
		if ($urandom_range(0, 99) < 85)
			for (int k = 0; k < NUM_SLOTS; k++)
				if (bank_state[(base + k) % NUM_SLOTS] != mtb_pkg::SS_FREE)
					return 4'((base + k) % NUM_SLOTS);
		return 4'(base);
	endfunction

	function automatic logic [7:0] pick_tag();
		if ($urandom_range(0, 99) < 80)
			return tag_pool[$urandom_range(0, 3)];
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [31:0] tick_delta();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return pick_between(1, 20);
		if (r < 80)
			return '0;
		if (r < 90)
			return pick_between(-20, -1);
		return $urandom;
	endfunction

	function automatic logic [31:0] set_duration();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return pick_between(1, 60);
		if (r < 90)
			return pick_between(-10, 0);
		return $urandom;
	endfunction

	// stretches of steady flow on either side
	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0)
			send_calm <= !send_calm;
		if ($urandom_range(0, 63) == 0)
			sink_calm <= !sink_calm;
	end

	// input beat accepted: update the shadow bank
	always @(posedge clk) begin : take_op
		timer_op_t op;
		in_beat <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			op.func = mtb_pkg::func_t'(op_func);
			op.slot = op_slot;
			op.amount = op_amount;
			op.looping = op_looping;
			op.owner = op_owner;
			op.drain = 1'b0;
			op_count[op_func]++;
			bank_step(op);
		end
	end

	// operation driver
	always @(negedge clk) begin : drive_ops
		timer_op_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_beat) begin
			// hold the beat until it is taken
		end else if (send_gap != 0) begin
			in_valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (op_queue.size() != 0 &&
				!(op_queue[0].drain && due_events.size() != 0)) begin
			nxt = op_queue.pop_front();
			op_func <= nxt.func;
			op_slot <= nxt.slot;
			op_amount <= nxt.amount;
			op_looping <= nxt.looping;
			op_owner <= nxt.owner;
			in_valid <= 1'b1;
			send_gap <= pick_gap(send_calm);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// result backpressure
	always @(negedge clk) begin : drive_sink
		int g;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (sink_wait != 0) begin
			out_ready <= 1'b0;
			sink_wait <= sink_wait - 1;
		end else begin
			g = pick_gap(sink_calm);
			if (g == 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				sink_wait <= g - 1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin : check_results
		timer_event_t exp_ev;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (res_kind == mtb_pkg::K_EXPIRED)
				expiries_seen++;
			if (res_status == mtb_pkg::S_NO_FREE)
				refusals_seen++;
			if (res_status == mtb_pkg::S_UNKNOWN)
				unknown_seen++;
			if (due_events.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("unexpected result at cycle %0d: kind %0d slot %0d remaining %0d",
						cycles, res_kind, res_slot, $signed(res_remaining));
			end else begin
				exp_ev = due_events.pop_front();
				if (res_kind !== exp_ev.kind || res_slot !== exp_ev.slot ||
						res_remaining !== exp_ev.remaining || res_status !== exp_ev.status ||
						res_last !== exp_ev.last) begin
					errors++;
					if (errors <= REPORT_LIMIT) begin
						$display("result mismatch at cycle %0d: expected kind %0d slot %0d %s",
							cycles, exp_ev.kind, exp_ev.slot,
							$sformatf("remaining %0d status %0d last %0d",
								$signed(exp_ev.remaining), exp_ev.status, exp_ev.last));
						$display("  got kind %0d slot %0d remaining %0d status %0d last %0d",
							res_kind, res_slot, $signed(res_remaining), res_status, res_last);
					end
				end
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				due_events.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin : stimulus
		int  scen;
		int  n;
		bit  first;
		for (int i = 0; i < NUM_SLOTS; i++)
			bank_state[i] = mtb_pkg::SS_FREE;
		for (int i = 0; i < 8; i++)
			op_count[i] = 0;
		for (int i = 0; i < 4; i++)
			tag_pool[i] = 8'($urandom_range(0, 255));

		// directed: extremes, saturation, every operation, stale handles
		push_op(mtb_pkg::F_TICK,      4'd0,  32'h0000_0000, 1'b0, 8'h00, 1'b0);
		push_op(mtb_pkg::F_SET,       4'd0,  32'h7fff_ffff, 1'b1, 8'hff, 1'b0);
		push_op(mtb_pkg::F_SET,       4'd0,  32'h8000_0000, 1'b0, 8'h00, 1'b0);
		push_op(mtb_pkg::F_SET,       4'd0,  32'h0000_0000, 1'b1, 8'h5a, 1'b0);
		push_op(mtb_pkg::F_READ,      4'd0,  32'h0000_0000, 1'b0, 8'h00, 1'b0);
		push_op(mtb_pkg::F_ADD,       4'd0,  32'h0000_0005, 1'b0, 8'h00, 1'b0);
		push_op(mtb_pkg::F_READ,      4'd0,  32'h0000_0000, 1'b0, 8'h00, 1'b0);
		push_op(mtb_pkg::F_ADD,       4'd1,  32'h8000_0000, 1'b0, 8'h00, 1'b0);
		push_op(mtb_pkg::F_READ,      4'd1,  32'h0000_0000, 1'b0, 8'h00, 1'b0);
		// one-shot at the floor and periodic zero both expire
		push_op(mtb_pkg::F_TICK,      4'd0,  32'h0000_0001, 1'b0, 8'h00, 1'b0);
		// negative delta drives the remaining time to the ceiling
		push_op(mtb_pkg::F_TICK,      4'd0,  32'h8000_0000, 1'b0, 8'h00, 1'b0);
		push_op(mtb_pkg::F_PAUSE,     4'd0,  32'h0000_0000, 1'b0, 8'h00, 1'b0);
		push_op(mtb_pkg::F_PAUSE,     4'd0,  32'h0000_0000, 1'b0, 8'h00, 1'b0);
		push_op(mtb_pkg::F_READ,      4'd0,  32'h0000_0000, 1'b0, 8'h00, 1'b0);
		push_op(mtb_pkg::F_TICK,      4'd0,  32'h7fff_ffff, 1'b0, 8'h00, 1'b0);
		push_op(mtb_pkg::F_UNPAUSE,   4'd0,  32'h0000_0000, 1'b0, 8'h00, 1'b0);
		push_op(mtb_pkg::F_UNPAUSE,   4'd0,  32'h0000_0000, 1'b0, 8'h00, 1'b0);
		push_op(mtb_pkg::F_CLEAR,     4'd1,  32'h0000_0000, 1'b0, 8'h00, 1'b0);
		push_op(mtb_pkg::F_READ,      4'd1,  32'h0000_0000, 1'b0, 8'h00, 1'b0);
		push_op(mtb_pkg::F_ADD,       4'd9,  32'hffff_ffff, 1'b0, 8'h00, 1'b0);
		push_op(mtb_pkg::F_CLEAR,     4'd2,  32'h0000_0000, 1'b0, 8'h00, 1'b0);
		push_op(mtb_pkg::F_CLR_OWNER, 4'd0,  32'h0000_0000, 1'b0, 8'hff, 1'b0);
		push_op(mtb_pkg::F_CLR_OWNER, 4'd0,  32'h0000_0000, 1'b0, 8'h33, 1'b0);
		push_op(mtb_pkg::F_READ,      4'd15, 32'h0000_0000, 1'b0, 8'h00, 1'b0);
		push_op(mtb_pkg::F_PAUSE,     4'd10, 32'h0000_0000, 1'b0, 8'h00, 1'b0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// random: first a drained fill of the whole bank, then mixed scenarios
		first = 1'b1;
		while (queued_ops < DIRECTED_OPS + RANDOM_OPS) begin
			while (op_queue.size() > 2)
				@(posedge clk);
			scen = first ? 95 : $urandom_range(0, 99);
			if (scen < 15) begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					push_op(mtb_pkg::F_SET, 4'($urandom_range(0, 15)), set_duration(),
						1'($urandom_range(0, 1)), pick_tag(), 1'b0);
			end else if (scen < 40) begin
				push_op(mtb_pkg::F_TICK, 4'($urandom_range(0, 15)), tick_delta(),
					1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					$urandom_range(0, 29) == 0);
			end else if (scen < 75) begin
				push_op(mtb_pkg::func_t'($urandom_range(mtb_pkg::F_CLEAR, mtb_pkg::F_ADD)),
					pick_live(),
					($urandom_range(0, 4) == 0) ? $urandom : pick_between(-20, 40),
					1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0);
			end else if (scen < 82) begin
				push_op(mtb_pkg::F_CLR_OWNER, 4'($urandom_range(0, 15)), $urandom,
					1'($urandom_range(0, 1)), pick_tag(), 1'b0);
			end else if (scen < 90) begin
				push_op(mtb_pkg::func_t'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
					$urandom, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0);
			end else begin
				// fill past capacity, then tick far enough to expire every timer that this fill set
				for (int i = 0; i <= NUM_SLOTS; i++)
					push_op(mtb_pkg::F_SET, 4'($urandom_range(0, 15)), pick_between(1, 40),
						1'($urandom_range(0, 1)), pick_tag(), first && i == 0);
				push_op(mtb_pkg::F_TICK, 4'd0, 32'd100, 1'b0, 8'h00, 1'b0);
				first = 1'b0;
			end
		end

		while (op_queue.size() != 0 || in_valid || due_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d operations: tick %0d, set %0d, clear %0d, pause %0d, unpause %0d, %s",
			queued_ops, op_count[mtb_pkg::F_TICK], op_count[mtb_pkg::F_SET],
			op_count[mtb_pkg::F_CLEAR], op_count[mtb_pkg::F_PAUSE],
			op_count[mtb_pkg::F_UNPAUSE],
			$sformatf("read %0d, add %0d, clear owner %0d", op_count[mtb_pkg::F_READ],
				op_count[mtb_pkg::F_ADD], op_count[mtb_pkg::F_CLR_OWNER]));
		$display("%0d results: %0d expiries, %0d full-bank refusals, %0d stale handles, %0d bad",
			results_seen, expiries_seen, refusals_seen, unknown_seen, errors);
		if (errors == 0 && due_events.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### multi_timer_bank_top.f
src/mtb_pkg.sv
src/mtb_ram.sv
src/multi_timer_bank_top.sv
test/tb_multi_timer_bank_top.sv
